/* rtl/ttf_pkg.sv */
// ---------------------------------------------------------------------------
// ttf_pkg: shared types and constants of the triangle tangent frame block
// Request payload structs and the fixed-width stage records of the
// square root and divider pipelines.
// ---------------------------------------------------------------------------
package ttf_pkg;

	localparam int COMPONENT_BITS_DEF = 16;
	localparam int POS_W = 48;
	localparam int TEX_W = 32;
	localparam int DIR_W = 48;

	// normalized magnitude width, top set bit at bit 29
	localparam int MAG_W = 30;
	localparam int SUM_W = 2 * MAG_W + 2;
	localparam int SQ_STEPS = SUM_W / 2;
	localparam int SQ_REM_W = SQ_STEPS + 3;
	localparam int ROOT_W = SQ_STEPS;
	localparam int DREM_W = ROOT_W + 2;
	localparam int QMAX_W = 31;

	typedef struct packed {
		logic [POS_W-1:0] v0_position;
		logic [POS_W-1:0] v1_position;
		logic [POS_W-1:0] v2_position;
		logic [TEX_W-1:0] v0_texcoord;
		logic [TEX_W-1:0] v1_texcoord;
		logic [TEX_W-1:0] v2_texcoord;
	} tri_t;

	typedef struct packed {
		logic [DIR_W-1:0] tangent_dir;
		logic [DIR_W-1:0] bitangent_dir;
		logic             degenerate;
	} frame_t;

	typedef struct packed {
		logic [1:0][SUM_W-1:0]      sum;
		logic [1:0][SQ_REM_W-1:0]   rem;
		logic [1:0][ROOT_W-1:0]     root;
		logic [1:0][2:0][MAG_W-1:0] m;
		logic [1:0][2:0]            neg;
		logic [1:0]                 zero;
		logic                       degen;
	} sq_t;

	typedef struct packed {
		logic [1:0][ROOT_W-1:0]      len;
		logic [1:0][2:0][DREM_W-1:0] rem;
		logic [1:0][2:0][QMAX_W-1:0] num;
		logic [1:0][2:0][QMAX_W-1:0] quo;
		logic [1:0][2:0]             neg;
		logic [1:0]                  zero;
		logic                        degen;
	} div_t;

endpackage

/* rtl/triangle_tangent_frame_top.sv */
// ---------------------------------------------------------------------------
// triangle_tangent_frame_top: per-triangle unit tangent and bitangent
// One triangle request enters per clock and one frame leaves per clock while
// the output is not stalled. The depth is set by the square root unit, one
// root bit per stage over 31 stages, followed by six restoring dividers that
// produce one quotient bit per stage. Edge and UV deltas, the UV determinant
// and the raw vectors are exact; each raw vector is block-normalized to 30
// bits, its length is the integer square root of the sum of squares, and
// each component is the rounded quotient scaled to Q1.(COMPONENT_BITS-2)
// with the sign of the determinant applied. A zero determinant gives zero
// vectors and raises degenerate. A stalled output holds the whole pipeline.
// ---------------------------------------------------------------------------
module triangle_tangent_frame_top import ttf_pkg::*; #(
	parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   tri_valid,
	output logic   tri_ready,
	input  tri_t   tri_data,
	output logic   frame_valid,
	input  logic   frame_ready,
	output frame_t frame_data
);

	localparam int CB = COMPONENT_BITS;
	localparam int EW = CB + 1;
	localparam int PW2 = 2 * CB + 2;
	localparam int DW = 2 * CB + 3;
	localparam int NW = (DW > MAG_W) ? DW : MAG_W;
	localparam int SHW = $clog2(NW + 1);
	localparam int F = CB - 2;
	localparam int QW = F + 1;
	localparam int PXW = (3 * CB > POS_W) ? 3 * CB : POS_W;
	localparam int TXW = (2 * CB > TEX_W) ? 2 * CB : TEX_W;
	localparam int OXW = (3 * CB > DIR_W) ? 3 * CB : DIR_W;

	logic adv;
	assign adv = !frame_valid || frame_ready;
	assign tri_ready = adv;

	// stage 1: lane unpack and deltas
	logic signed [CB-1:0] p [3][3];
	logic signed [CB-1:0] t [3][2];

	always_comb begin
		logic [PXW-1:0] pe [3];
		logic [TXW-1:0] te [3];
		pe[0] = PXW'(tri_data.v0_position);
		pe[1] = PXW'(tri_data.v1_position);
		pe[2] = PXW'(tri_data.v2_position);
		te[0] = TXW'(tri_data.v0_texcoord);
		te[1] = TXW'(tri_data.v1_texcoord);
		te[2] = TXW'(tri_data.v2_texcoord);
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				p[i][k] = pe[i][k*CB +: CB];
			end
			for (int k = 0; k < 2; k++) begin
				t[i][k] = te[i][k*CB +: CB];
			end
		end
	end

	logic                 v_s1;
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [EW-1:0] d1u_s1, d1v_s1, d2u_s1, d2v_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				e1_s1[k] <= EW'(p[1][k]) - EW'(p[0][k]);
				e2_s1[k] <= EW'(p[2][k]) - EW'(p[0][k]);
			end
			d1u_s1 <= EW'(t[1][0]) - EW'(t[0][0]);
			d1v_s1 <= EW'(t[1][1]) - EW'(t[0][1]);
			d2u_s1 <= EW'(t[2][0]) - EW'(t[0][0]);
			d2v_s1 <= EW'(t[2][1]) - EW'(t[0][1]);
		end
	end

	// stage 2: products
	logic                  v_s2;
	logic signed [PW2-1:0] pdet_s2 [2];
	logic signed [PW2-1:0] pt_s2 [3][2];
	logic signed [PW2-1:0] pb_s2 [3][2];

	always_ff @(posedge clk) begin
		if (adv) begin
			pdet_s2[0] <= PW2'(d1u_s1) * PW2'(d2v_s1);
			pdet_s2[1] <= PW2'(d2u_s1) * PW2'(d1v_s1);
			for (int k = 0; k < 3; k++) begin
				pt_s2[k][0] <= PW2'(d2v_s1) * PW2'(e1_s1[k]);
				pt_s2[k][1] <= PW2'(d1v_s1) * PW2'(e2_s1[k]);
				pb_s2[k][0] <= PW2'(d1u_s1) * PW2'(e2_s1[k]);
				pb_s2[k][1] <= PW2'(d2u_s1) * PW2'(e1_s1[k]);
			end
		end
	end

	// stage 3: determinant and raw vectors
	logic                 v_s3;
	logic signed [DW-1:0] det_s3;
	logic signed [DW-1:0] raw_s3 [2][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s3 <= DW'(pdet_s2[0]) - DW'(pdet_s2[1]);
			for (int k = 0; k < 3; k++) begin
				raw_s3[0][k] <= DW'(pt_s2[k][0]) - DW'(pt_s2[k][1]);
				raw_s3[1][k] <= DW'(pb_s2[k][0]) - DW'(pb_s2[k][1]);
			end
		end
	end

	// stage 4: sign and magnitude
	logic            v_s4;
	logic [DW-1:0]   mag_s4 [2][3];
	logic [DW-1:0]   orv_s4 [2];
	logic [1:0][2:0] neg_s4;
	logic            degen_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int v = 0; v < 2; v++) begin
				orv_s4[v] <= (raw_s3[v][0][DW-1] ? DW'(-raw_s3[v][0]) : DW'(raw_s3[v][0]))
					| (raw_s3[v][1][DW-1] ? DW'(-raw_s3[v][1]) : DW'(raw_s3[v][1]))
					| (raw_s3[v][2][DW-1] ? DW'(-raw_s3[v][2]) : DW'(raw_s3[v][2]));
				for (int k = 0; k < 3; k++) begin
					mag_s4[v][k] <= raw_s3[v][k][DW-1] ? DW'(-raw_s3[v][k])
						: DW'(raw_s3[v][k]);
					neg_s4[v][k] <= raw_s3[v][k][DW-1] ^ det_s3[DW-1];
				end
			end
			degen_s4 <= (det_s3 == '0);
		end
	end

	// stage 5: leading one of the block
	logic            v_s5;
	logic [SHW-1:0]  maxlen_s5 [2];
	logic [DW-1:0]   mag_s5 [2][3];
	logic [1:0][2:0] neg_s5;
	logic            degen_s5;
	logic [SHW-1:0]  ml_c [2];

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			ml_c[v] = '0;
			for (int i = 0; i < DW; i++) begin
				if (orv_s4[v][i]) begin
					ml_c[v] = SHW'(i + 1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			maxlen_s5 <= ml_c;
			mag_s5    <= mag_s4;
			neg_s5    <= neg_s4;
			degen_s5  <= degen_s4;
		end
	end

	// stage 6: block shift to 30 bits
	logic                       v_s6;
	logic [1:0][2:0][MAG_W-1:0] m_s6;
	logic [1:0]                 zero_s6;
	logic [1:0][2:0]            neg_s6;
	logic                       degen_s6;
	logic [1:0][2:0][MAG_W-1:0] m_c;

	always_comb begin
		logic [NW-1:0] ext;
		for (int v = 0; v < 2; v++) begin
			for (int k = 0; k < 3; k++) begin
				ext = NW'(mag_s5[v][k]) << (SHW'(NW) - maxlen_s5[v]);
				m_c[v][k] = ext[NW-1 -: MAG_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s6 <= m_c;
			for (int v = 0; v < 2; v++) begin
				zero_s6[v] <= (maxlen_s5[v] == '0) || degen_s5;
			end
			neg_s6   <= neg_s5;
			degen_s6 <= degen_s5;
		end
	end

	// stage 7: squares
	logic                         v_s7;
	logic [1:0][2:0][2*MAG_W-1:0] sq_s7;
	logic [1:0][2:0][MAG_W-1:0]   m_s7;
	logic [1:0]                   zero_s7;
	logic [1:0][2:0]              neg_s7;
	logic                         degen_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int v = 0; v < 2; v++) begin
				for (int k = 0; k < 3; k++) begin
					sq_s7[v][k] <= (2*MAG_W)'(m_s6[v][k]) * (2*MAG_W)'(m_s6[v][k]);
				end
			end
			m_s7     <= m_s6;
			zero_s7  <= zero_s6;
			neg_s7   <= neg_s6;
			degen_s7 <= degen_s6;
		end
	end

	// stage 8 feeds the square root pipeline: sum of squares
	sq_t  sq_s [SQ_STEPS+1];
	logic sqv_s [SQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int v = 0; v < 2; v++) begin
				sq_s[0].sum[v] <= SUM_W'(sq_s7[v][0]) + SUM_W'(sq_s7[v][1])
					+ SUM_W'(sq_s7[v][2]);
			end
			sq_s[0].rem   <= '0;
			sq_s[0].root  <= '0;
			sq_s[0].m     <= m_s7;
			sq_s[0].neg   <= neg_s7;
			sq_s[0].zero  <= zero_s7;
			sq_s[0].degen <= degen_s7;
		end
	end

	// integer square root, one root bit per stage
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		localparam int J = SQ_STEPS - 1 - i;
		sq_t sn;

		always_comb begin
			logic [SQ_REM_W-1:0] rs;
			logic [SQ_REM_W-1:0] trial;
			sn = sq_s[i];
			for (int v = 0; v < 2; v++) begin
				rs = {sq_s[i].rem[v][SQ_REM_W-3:0], sq_s[i].sum[v][2*J +: 2]};
				trial = SQ_REM_W'({sq_s[i].root[v], 2'b01});
				if (rs >= trial) begin
					sn.rem[v]  = rs - trial;
					sn.root[v] = {sq_s[i].root[v][ROOT_W-2:0], 1'b1};
				end else begin
					sn.rem[v]  = rs;
					sn.root[v] = {sq_s[i].root[v][ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[i+1] <= sn;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[i+1] <= 1'b0;
			end else if (adv) begin
				sqv_s[i+1] <= sqv_s[i];
			end
		end
	end

	// divider setup: numerator m * 2^F + len / 2
	div_t dv_s [QW+1];
	logic dvv_s [QW+1];

	always_ff @(posedge clk) begin
		logic [2*QMAX_W-1:0] nn;
		if (adv) begin
			for (int v = 0; v < 2; v++) begin
				dv_s[0].len[v] <= sq_s[SQ_STEPS].root[v];
				for (int k = 0; k < 3; k++) begin
					nn = ((2*QMAX_W)'(sq_s[SQ_STEPS].m[v][k]) << F)
						+ (2*QMAX_W)'(sq_s[SQ_STEPS].root[v] >> 1);
					dv_s[0].rem[v][k] <= DREM_W'(nn >> QW);
					dv_s[0].num[v][k] <= nn[QMAX_W-1:0];
				end
			end
			dv_s[0].quo   <= '0;
			dv_s[0].neg   <= sq_s[SQ_STEPS].neg;
			dv_s[0].zero  <= sq_s[SQ_STEPS].zero;
			dv_s[0].degen <= sq_s[SQ_STEPS].degen;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int J = QW - 1 - i;
		div_t dn;

		always_comb begin
			logic [DREM_W-1:0] rs;
			dn = dv_s[i];
			for (int v = 0; v < 2; v++) begin
				for (int k = 0; k < 3; k++) begin
					rs = {dv_s[i].rem[v][k][DREM_W-2:0], dv_s[i].num[v][k][J]};
					if (rs >= DREM_W'(dv_s[i].len[v])) begin
						dn.rem[v][k] = rs - DREM_W'(dv_s[i].len[v]);
						dn.quo[v][k] = {dv_s[i].quo[v][k][QMAX_W-2:0], 1'b1};
					end else begin
						dn.rem[v][k] = rs;
						dn.quo[v][k] = {dv_s[i].quo[v][k][QMAX_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[i+1] <= dn;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[i+1] <= 1'b0;
			end else if (adv) begin
				dvv_s[i+1] <= dvv_s[i];
			end
		end
	end

	// sign, pack and output register
	frame_t res_c;

	always_comb begin
		logic [OXW-1:0] pk [2];
		logic [CB-1:0]  cq;
		for (int v = 0; v < 2; v++) begin
			pk[v] = '0;
			for (int k = 0; k < 3; k++) begin
				cq = CB'(dv_s[QW].quo[v][k]);
				if (dv_s[QW].zero[v]) begin
					pk[v][k*CB +: CB] = '0;
				end else if (dv_s[QW].neg[v][k]) begin
					pk[v][k*CB +: CB] = -cq;
				end else begin
					pk[v][k*CB +: CB] = cq;
				end
			end
		end
		res_c.tangent_dir   = pk[0][DIR_W-1:0];
		res_c.bitangent_dir = pk[1][DIR_W-1:0];
		res_c.degenerate    = dv_s[QW].degen;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_data <= res_c;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			sqv_s[0]    <= 1'b0;
			dvv_s[0]    <= 1'b0;
			frame_valid <= 1'b0;
		end else if (adv) begin
			v_s1        <= tri_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			sqv_s[0]    <= v_s7;
			dvv_s[0]    <= sqv_s[SQ_STEPS];
			frame_valid <= dvv_s[QW];
		end
	end

	// a degenerate frame carries zero vectors
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_data.degenerate |->
			frame_data.tangent_dir == '0 && frame_data.bitangent_dir == '0)
		else $error("degenerate frame with nonzero vectors");

	// a stalled output freezes the pipeline head
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> v_s1 == $past(v_s1))
		else $error("pipeline moved during stall");

	// normalized block keeps the root at or above 2^29
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		sqv_s[SQ_STEPS] && !sq_s[SQ_STEPS].zero[0] && !sq_s[SQ_STEPS].zero[1] |->
			sq_s[SQ_STEPS].root[0][ROOT_W-1:ROOT_W-2] != '0
			&& sq_s[SQ_STEPS].root[1][ROOT_W-1:ROOT_W-2] != '0)
		else $error("square root below normalized range");

	// tangent unit components never exceed one
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		dvv_s[QW] && !dv_s[QW].zero[0] |->
			dv_s[QW].quo[0][0] <= (QMAX_W'(1) << F)
			&& dv_s[QW].quo[0][1] <= (QMAX_W'(1) << F)
			&& dv_s[QW].quo[0][2] <= (QMAX_W'(1) << F))
		else $error("tangent component above one");

endmodule

/* tb/sv/triangle_tangent_frame_top_tb.sv */
// ---------------------------------------------------------------------------
// triangle_tangent_frame_top_tb: self-checking bench for the tangent frame block
// Drives directed and random triangles through the request channel under
// several idle and stall patterns, predicts each unit tangent and bitangent
// with an independent fixed-point model and compares every frame in order.
// ---------------------------------------------------------------------------
module triangle_tangent_frame_top_tb;
	import ttf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = COMPONENT_BITS_DEF;
	localparam int FRAC = CB - 2;

	class frame_scoreboard;
		frame_t pending[$];
		int errors;
		int checked;
		int degen_seen;

		function automatic longint lane(logic [63:0] w, int k);
			logic [CB-1:0] v;
			if (k * CB >= 64)
				return 0;
			v = CB'(w >> (k * CB));
			return longint'($signed(v));
		endfunction

		function automatic logic [DIR_W-1:0] unit_dir(logic signed [127:0] r[3], bit flip);
			logic [127:0] mg[3];
			logic [63:0] m[3];
			logic [63:0] acc, len, q;
			logic [DIR_W-1:0] packed_dir;
			int maxb, b, k, j;
			bit neg;
			maxb = 0;
			packed_dir = '0;
			for (k = 0; k < 3; k++) begin
				mg[k] = r[k] < 0 ? -r[k] : r[k];
				b = 0;
				for (j = 0; j < 128; j++)
					if (mg[k][j])
						b = j + 1;
				if (b > maxb)
					maxb = b;
			end
			if (maxb == 0)
				return '0;
			acc = 0;
			for (k = 0; k < 3; k++) begin
				if (maxb > MAG_W)
					m[k] = 64'(mg[k] >> (maxb - MAG_W));
				else
					m[k] = 64'(mg[k] << (MAG_W - maxb));
				acc += m[k] * m[k];
			end
			len = 0;
			for (j = 31; j >= 0; j--)
				if ((len + (64'd1 << j)) * (len + (64'd1 << j)) <= acc)
					len += 64'd1 << j;
			for (k = 0; k < 3; k++) begin
				q = ((m[k] << FRAC) + (len >> 1)) / len;
				neg = (r[k] < 0) != flip;
				if (k * CB < DIR_W)
					packed_dir |= DIR_W'((neg ? -q : q) & ((64'd1 << CB) - 1)) << (k * CB);
			end
			return packed_dir;
		endfunction

		function void note_triangle(tri_t t);
			longint p[3][3], uv[3][2];
			logic signed [127:0] det, tr[3], br[3], e1, e2, d1u, d1v, d2u, d2v;
			logic [63:0] pw[3], tw[3];
			frame_t f;
			pw[0] = 64'(t.v0_position); pw[1] = 64'(t.v1_position);
			pw[2] = 64'(t.v2_position);
			tw[0] = 64'(t.v0_texcoord); tw[1] = 64'(t.v1_texcoord);
			tw[2] = 64'(t.v2_texcoord);
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++)
					p[i][k] = lane(pw[i], k);
				for (int k = 0; k < 2; k++)
					uv[i][k] = lane(tw[i], k);
			end
			d1u = 128'(uv[1][0] - uv[0][0]);
			d1v = 128'(uv[1][1] - uv[0][1]);
			d2u = 128'(uv[2][0] - uv[0][0]);
			d2v = 128'(uv[2][1] - uv[0][1]);
			det = d1u * d2v - d2u * d1v;
			f = '0;
			if (det == 0) begin
				f.degenerate = 1'b1;
				degen_seen++;
			end else begin
				for (int k = 0; k < 3; k++) begin
					e1 = 128'(p[1][k] - p[0][k]);
					e2 = 128'(p[2][k] - p[0][k]);
					tr[k] = d2v * e1 - d1v * e2;
					br[k] = d1u * e2 - d2u * e1;
				end
				f.tangent_dir = unit_dir(tr, det < 0);
				f.bitangent_dir = unit_dir(br, det < 0);
			end
			pending = {pending, f};
		endfunction

		function void check_frame(frame_t got);
			frame_t exp_f;
			if (pending.size() == 0) begin
				$display("%0t: unexpected frame %h", $time, got);
				errors++;
				return;
			end
			exp_f = pending.pop_front();
			checked++;
			if (got.tangent_dir !== exp_f.tangent_dir) begin
				$display("%0t: tangent expected %h actual %h", $time,
					exp_f.tangent_dir, got.tangent_dir);
				errors++;
			end
			if (got.bitangent_dir !== exp_f.bitangent_dir) begin
				$display("%0t: bitangent expected %h actual %h", $time,
					exp_f.bitangent_dir, got.bitangent_dir);
				errors++;
			end
			if (got.degenerate !== exp_f.degenerate) begin
				$display("%0t: degenerate expected %b actual %b", $time,
					exp_f.degenerate, got.degenerate);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic tri_valid;
	logic tri_ready;
	tri_t tri_data;
	logic frame_valid;
	logic frame_ready;
	frame_t frame_data;

	frame_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int sent;

	triangle_tangent_frame_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tri_valid(tri_valid),
		.tri_ready(tri_ready),
		.tri_data(tri_data),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame_data(frame_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// sender gaps, one request per call
	task automatic send_triangle(tri_t t);
		bit got;
		while ($urandom_range(99) < send_idle_pct) begin
			tri_valid <= 1'b0;
			@(posedge clk);
		end
		tri_valid <= 1'b1;
		tri_data <= t;
		do begin
			@(negedge clk);
			got = tri_ready;
			@(posedge clk);
		end while (!got);
		sb.note_triangle(t);
		sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && frame_valid && frame_ready)
			sb.check_frame(frame_data);
		frame_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [15:0] rnd_comp();
		case ($urandom_range(5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic tri_t rnd_triangle();
		tri_t t;
		logic [15:0] c[9];
		logic [15:0] u[6];
		for (int i = 0; i < 9; i++)
			c[i] = rnd_comp();
		for (int i = 0; i < 6; i++)
			u[i] = rnd_comp();
		case ($urandom_range(9))
			0: begin
				u[4] = u[0]; u[5] = u[1];
			end
			1: begin
				u[2] = u[0]; u[4] = u[0];
			end
			2: begin
				c[6] = c[0]; c[7] = c[1]; c[8] = c[2];
			end
			3: begin
				c[3] = c[0] + 16'd1; c[4] = c[1]; c[5] = c[2];
				c[6] = c[0] + 16'd2; c[7] = c[1]; c[8] = c[2];
			end
			default: ;
		endcase
		t.v0_position = {c[2], c[1], c[0]};
		t.v1_position = {c[5], c[4], c[3]};
		t.v2_position = {c[8], c[7], c[6]};
		t.v0_texcoord = {u[1], u[0]};
		t.v1_texcoord = {u[3], u[2]};
		t.v2_texcoord = {u[5], u[4]};
		return t;
	endfunction

	function automatic tri_t mk_tri(logic [15:0] a, logic [15:0] b, logic [15:0] uu,
			logic [15:0] vv);
		tri_t t;
		t.v0_position = '0;
		t.v1_position = {16'd0, 16'd0, a};
		t.v2_position = {16'd0, b, 16'd0};
		t.v0_texcoord = '0;
		t.v1_texcoord = {16'd0, uu};
		t.v2_texcoord = {vv, 16'd0};
		return t;
	endfunction

	initial begin
		tri_t t;
		sb = new();
		arst_n = 1'b0;
		tri_valid = 1'b0;
		tri_data = '0;
		frame_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: basic frame, flipped determinant, extremes, degenerate cases
		send_triangle(mk_tri(16'h0100, 16'h0100, 16'h2000, 16'h2000));
		send_triangle(mk_tri(16'h0100, 16'h0100, 16'he000, 16'h2000));
		send_triangle(mk_tri(16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
		send_triangle(mk_tri(16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
		send_triangle(mk_tri(16'h0001, 16'h0001, 16'h0001, 16'h0001));
		send_triangle(mk_tri(16'h0100, 16'h0100, 16'h0000, 16'h2000));
		send_triangle('0);
		send_triangle('1);
		t = mk_tri(16'h0100, 16'h0100, 16'h2000, 16'h2000);
		t.v2_position = t.v1_position;
		send_triangle(t);
		t.v0_position = {16'h8000, 16'h8000, 16'h8000};
		t.v1_position = {16'h7fff, 16'h7fff, 16'h7fff};
		t.v2_position = {16'h8000, 16'h7fff, 16'h8000};
		t.v0_texcoord = {16'h8000, 16'h8000};
		t.v1_texcoord = {16'h8000, 16'h7fff};
		t.v2_texcoord = {16'h7fff, 16'h8000};
		send_triangle(t);
		t.v0_texcoord = {16'h7fff, 16'h7fff};
		send_triangle(t);
		for (int i = 0; i < 8; i++)
			send_triangle(rnd_triangle());

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			for (int i = 0; i < 420; i++)
				send_triangle(rnd_triangle());
		end
		tri_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d triangles, checked %0d frames, %0d degenerate",
			sent, sb.checked, sb.degen_seen);
		$display("phases: free flow, sender gaps, receiver stalls, both");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2ms;
		$display("timeout");
		$display("FAIL");
		$finish;
	end

endmodule
